@@ rtl/core/rgb_box_average_downscaler_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the box-average downscaler
// Shared concurrent-check forms; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_AVERAGE_DOWNSCALER_UNIT_DEFINES_SVH
`define RGB_BOX_AVERAGE_DOWNSCALER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RBAD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RBAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rbad_pkg.sv @@
// ----------------------------------------------------------------------------
// rbad_pkg
// Constants, types and the reciprocal table of the box-average downscaler.
// ----------------------------------------------------------------------------
package rbad_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MAX_FACTOR  = 16;

  localparam int CH_W        = 8;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int SUB_W       = $clog2(MAX_FACTOR);
  localparam int FCT_W       = SUB_W + 1;
  localparam int WID_W       = COL_W + 1;
  localparam int HGT_W       = ROW_W + 1;
  localparam int POS_W       = WID_W + 1;
  localparam int RPOS_W      = HGT_W + 1;
  localparam int RSUM_W      = CH_W + SUB_W;       // one block row, one channel
  localparam int SUM_W       = CH_W + 2 * SUB_W;   // whole block, one channel
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // ceil(2^24 / (f*f)) for f = 1 .. 16, indexed by f - 1
  localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_FACTOR] = '{
    25'd16777216, 25'd4194304, 25'd1864136, 25'd1048576,
    25'd671089,   25'd466034,  25'd342393,  25'd262144,
    25'd207127,   25'd167773,  25'd138655,  25'd116509,
    25'd99274,    25'd85599,   25'd74566,   25'd65536
  };

  // Clamped configuration as seen by the datapath
  typedef struct packed {
    logic [FCT_W-1:0] factor;
    logic [SUB_W-1:0] f_m1;
    logic [WID_W-1:0] width;
    logic [COL_W-1:0] w_m1;
    logic [HGT_W-1:0] height;
    logic [ROW_W-1:0] h_m1;
    logic             fit_w;
    logic             fit_h;
  } cfg_t;

  // One completed block row segment, handed from front to back
  typedef struct packed {
    logic [RSUM_W-1:0] blue;
    logic [RSUM_W-1:0] green;
    logic [RSUM_W-1:0] red;
    logic [COL_W-1:0]  col;
    logic              first_row;
    logic              last_row;
    logic              frame_last;
  } blk_t;

  // Per-column partial sums
  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } total_t;

endpackage

@@ rtl/core/rbad_front.sv @@
// ----------------------------------------------------------------------------
// rbad_front
// Raster position tracking and row-segment accumulation; pushes block records.
// ----------------------------------------------------------------------------
module rbad_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    restart,
  input  rbad_pkg::cfg_t          cfg,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [23:0]             s_tdata,
  output logic                    push,
  output rbad_pkg::blk_t          push_data,
  input  logic                    q_full
);
  import rbad_pkg::*;

  logic [COL_W-1:0]  pixel_column;
  logic [ROW_W-1:0]  pixel_row;
  logic [SUB_W-1:0]  sub_column;
  logic [SUB_W-1:0]  sub_row;
  logic [COL_W-1:0]  output_column;
  logic [RSUM_W-1:0] sum_red;
  logic [RSUM_W-1:0] sum_green;
  logic [RSUM_W-1:0] sum_blue;
  logic              col_active;
  logic              row_active;
  logic              fresh;

  logic              accept;
  logic              eff_col;
  logic              eff_row;
  logic              in_region;
  logic              blk_done;
  logic              end_of_row;
  logic              col_fits_next;
  logic              row_fits_next;
  logic [RSUM_W-1:0] red_next;
  logic [RSUM_W-1:0] green_next;
  logic [RSUM_W-1:0] blue_next;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && !q_full;

  // Just after restart the activity flags come straight from the config
  assign eff_col   = fresh ? cfg.fit_w : col_active;
  assign eff_row   = fresh ? cfg.fit_h : row_active;
  assign in_region = eff_col && eff_row;
  assign blk_done  = sub_column == cfg.f_m1;
  assign end_of_row = pixel_column == cfg.w_m1;

  // Does a whole block still fit after the current one
  assign col_fits_next = (POS_W'(pixel_column) + POS_W'(1) + POS_W'(cfg.factor))
                         <= POS_W'(cfg.width);
  assign row_fits_next = (RPOS_W'(pixel_row) + RPOS_W'(1) + RPOS_W'(cfg.factor))
                         <= RPOS_W'(cfg.height);

  assign red_next   = sum_red   + RSUM_W'(s_tdata[7:0]);
  assign green_next = sum_green + RSUM_W'(s_tdata[15:8]);
  assign blue_next  = sum_blue  + RSUM_W'(s_tdata[23:16]);

  assign push = accept && in_region && blk_done;

  always_comb begin
    push_data.red        = red_next;
    push_data.green      = green_next;
    push_data.blue       = blue_next;
    push_data.col        = output_column;
    push_data.first_row  = sub_row == '0;
    push_data.last_row   = sub_row == cfg.f_m1;
    push_data.frame_last = (sub_row == cfg.f_m1) && !row_fits_next && !col_fits_next;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pixel_column  <= '0;
      pixel_row     <= '0;
      sub_column    <= '0;
      sub_row       <= '0;
      output_column <= '0;
      sum_red       <= '0;
      sum_green     <= '0;
      sum_blue      <= '0;
      col_active    <= 1'b0;
      row_active    <= 1'b0;
      fresh         <= 1'b1;
    end else if (accept) begin
      fresh      <= 1'b0;
      col_active <= eff_col;
      row_active <= eff_row;
      if (in_region) begin
        if (blk_done) begin
          sum_red       <= '0;
          sum_green     <= '0;
          sum_blue      <= '0;
          sub_column    <= '0;
          output_column <= output_column + COL_W'(1);
          col_active    <= col_fits_next;
        end else begin
          sum_red    <= red_next;
          sum_green  <= green_next;
          sum_blue   <= blue_next;
          sub_column <= sub_column + SUB_W'(1);
        end
      end
      if (end_of_row) begin
        pixel_column  <= '0;
        sub_column    <= '0;
        output_column <= '0;
        sum_red       <= '0;
        sum_green     <= '0;
        sum_blue      <= '0;
        col_active    <= cfg.fit_w;
        if (eff_row) begin
          if (sub_row == cfg.f_m1) begin
            sub_row    <= '0;
            row_active <= row_fits_next;
          end else begin
            sub_row <= sub_row + SUB_W'(1);
          end
        end
        if (pixel_row == cfg.h_m1) begin
          pixel_row  <= '0;
          sub_row    <= '0;
          row_active <= cfg.fit_h;
        end else begin
          pixel_row <= pixel_row + ROW_W'(1);
        end
      end else begin
        pixel_column <= pixel_column + COL_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/rbad_queue.sv @@
// ----------------------------------------------------------------------------
// rbad_queue
// Short first-in first-out queue of block records between front and back.
// ----------------------------------------------------------------------------
module rbad_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rbad_pkg::blk_t push_data,
  output logic           full,
  input  logic           pop,
  output rbad_pkg::blk_t pop_data,
  output logic           empty
);
  import rbad_pkg::*;

  blk_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = count == QCNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/rbad_back.sv @@
// ----------------------------------------------------------------------------
// rbad_back
// Column-sum store, block totals, reciprocal divide and output register.
// ----------------------------------------------------------------------------
`include "rgb_box_average_downscaler_unit_defines.svh"

module rbad_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rbad_pkg::SUB_W-1:0]    f_m1,
  input  logic                          q_empty,
  input  rbad_pkg::blk_t                q_data,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,
  output logic                          m_tlast
);
  import rbad_pkg::*;

  total_t             col_mem [MAX_WIDTH];
  total_t             rdata;
  total_t             fwd_data;
  logic               fwd_valid;

  logic               s1_valid;
  blk_t               s1;
  logic               s2_valid;
  total_t             s2_total;
  logic               s2_last;
  logic [RECIP_W-1:0] s2_recip;

  total_t             prior;
  total_t             total;
  logic               s1_fire;
  logic               s2_fire;
  logic               mem_we;
  logic [PROD_W-1:0]  prod_red;
  logic [PROD_W-1:0]  prod_green;
  logic [PROD_W-1:0]  prod_blue;

  assign s2_fire = s2_valid && (!m_tvalid || m_tready);
  assign s1_fire = s1_valid && (!s1.last_row || !s2_valid || s2_fire);
  assign pop     = !q_empty && (!s1_valid || s1_fire);
  assign mem_we  = s1_fire && !s1.last_row;

  // First block row starts from zero; a write just behind is forwarded
  always_comb begin
    if (s1.first_row) begin
      prior = '0;
    end else if (fwd_valid) begin
      prior = fwd_data;
    end else begin
      prior = rdata;
    end
    total.red   = prior.red   + SUM_W'(s1.red);
    total.green = prior.green + SUM_W'(s1.green);
    total.blue  = prior.blue  + SUM_W'(s1.blue);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      col_mem[s1.col] <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata <= col_mem[q_data.col];
      s1    <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      s1_valid  <= 1'b0;
    end else begin
      if (pop || s1_fire) begin
        fwd_valid <= pop && mem_we && (q_data.col == s1.col);
        s1_valid  <= pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fwd_data <= total;
    end
  end

  // Stage two: block total held for the multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_fire && s1.last_row) begin
      s2_valid <= 1'b1;
    end else if (s2_fire) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1.last_row) begin
      s2_total <= total;
      s2_last  <= s1.frame_last;
      s2_recip <= RECIP_TABLE[f_m1];
    end
  end

  assign prod_red   = PROD_W'(s2_total.red)   * PROD_W'(s2_recip);
  assign prod_green = PROD_W'(s2_total.green) * PROD_W'(s2_recip);
  assign prod_blue  = PROD_W'(s2_total.blue)  * PROD_W'(s2_recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      m_tdata <= {prod_blue[RECIP_SHIFT +: CH_W], prod_green[RECIP_SHIFT +: CH_W],
                  prod_red[RECIP_SHIFT +: CH_W]};
      m_tlast <= s2_last;
    end
  end

  `RBAD_ASSERT(fwd_needs_block, fwd_valid, s1_valid, "forward flag set with stage one empty")
  `RBAD_ASSERT_NEXT(pop_loads_s1, pop, s1_valid, "popped record missing from stage one")
  `RBAD_ASSERT_NEXT(s2_holds, s2_valid && !s2_fire, s2_valid && $stable(s2_total), "stalled total moved")

endmodule

@@ rtl/core/rgb_box_average_downscaler_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_box_average_downscaler_unit
// Box-average RGB downscaler: averages each factor-by-factor block of a
// raster frame per channel and emits one pixel per complete block.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: red, green, blue
//  m_*     | out | m_tvalid/m_tready  | m_tdata: red, green, blue; m_tlast
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
//  One pixel a cycle sustained while the queue has room; the front and back each move one item a cycle unless stalled.
//  After its last pixel, a block's average passes through queue hand-off, column-store
//  read and add, and the reciprocal multiply into the output register.
//  The four-entry queue lets pixels keep flowing while the output is stalled;
//  the input stalls only once the queue is full.
//  rst is synchronous; a scale, width or height write restarts the frame counters.
// ----------------------------------------------------------------------------
module rgb_box_average_downscaler_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [23:0]                         s_tdata,   // red_in, green_in, blue_in
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [23:0]                         m_tdata,   // red_out, green_out, blue_out
  output logic                                m_tlast,   // frame_last
  input  logic                                cfg_we,
  input  logic [rbad_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbad_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rbad_pkg::*;

  logic [FCT_W-1:0] factor_reg;
  logic [WID_W-1:0] frame_width;
  logic [HGT_W-1:0] frame_height;
  cfg_t             cfg;
  logic             restart;
  logic             push;
  blk_t             push_data;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  blk_t             q_data;

  // Configuration registers; only the listed indexes restart the frame
  assign restart = cfg_we && (cfg_index == CFG_SCALE || cfg_index == CFG_WIDTH ||
                              cfg_index == CFG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      factor_reg   <= FCT_W'(1);
      frame_width  <= WID_W'(MAX_WIDTH);
      frame_height <= HGT_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE:  factor_reg   <= cfg_data[FCT_W-1:0];
        CFG_WIDTH:  frame_width  <= cfg_data[WID_W-1:0];
        CFG_HEIGHT: frame_height <= cfg_data[HGT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp: zero counts as one, large values saturate
  always_comb begin
    if (factor_reg == '0) begin
      cfg.factor = FCT_W'(1);
    end else if (factor_reg > FCT_W'(MAX_FACTOR)) begin
      cfg.factor = FCT_W'(MAX_FACTOR);
    end else begin
      cfg.factor = factor_reg;
    end
    if (frame_width == '0) begin
      cfg.width = WID_W'(1);
    end else if (frame_width > WID_W'(MAX_WIDTH)) begin
      cfg.width = WID_W'(MAX_WIDTH);
    end else begin
      cfg.width = frame_width;
    end
    if (frame_height == '0) begin
      cfg.height = HGT_W'(1);
    end else if (frame_height > HGT_W'(MAX_HEIGHT)) begin
      cfg.height = HGT_W'(MAX_HEIGHT);
    end else begin
      cfg.height = frame_height;
    end
    cfg.f_m1  = SUB_W'(cfg.factor - FCT_W'(1));
    cfg.w_m1  = COL_W'(cfg.width - WID_W'(1));
    cfg.h_m1  = ROW_W'(cfg.height - HGT_W'(1));
    cfg.fit_w = WID_W'(cfg.factor) <= cfg.width;
    cfg.fit_h = HGT_W'(cfg.factor) <= cfg.height;
  end

  // Front: position counters and row-segment sums
  rbad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Hold completed row segments until the back takes them
  rbad_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // Back: column store, totals and division by the block area
  rbad_back u_back (
    .clk      (clk),
    .rst      (rst),
    .f_m1     (cfg.f_m1),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the box-average RGB downscaler. A queue-fed driver
// pushes pixels over the input stream with random gaps, and a monitor stalls
// the output stream at random. Every output pixel is compared with a local
// box-average predictor that follows each accepted input pixel.
// ----------------------------------------------------------------------------
module tb;
  import rbad_pkg::*;

  // Unused register slot: a write there must leave the frame counters alone
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES  = 16;    // comfortably past the queue and pipeline
  localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before giving up
  localparam int RANDOM_PIXELS = 1000;
  localparam int WIDE_PIXELS   = 300;
  localparam int MAX_GAP       = 18;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } px_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata = '0;    // red, green, blue
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;         // red, green, blue
  logic                  m_tlast;         // frame_last
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rgb_box_average_downscaler_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Box-average predictor: its own copy of the registers and frame position
  // --------------------------------------------------------------------------
  logic [FCT_W-1:0]  scale_reg;
  logic [WID_W-1:0]  width_reg;
  logic [HGT_W-1:0]  height_reg;

  int unsigned       cur_col, cur_row;   // position in the input frame
  int unsigned       blk_col, blk_row;   // position inside the current block
  int unsigned       out_col;            // output column being built
  logic [RSUM_W-1:0] acc_r, acc_g, acc_b;
  total_t            col_store [MAX_WIDTH];

  px_out_t           expected_px[$];
  logic [23:0]       pixel_q[$];
  int                pixels_queued = 0;
  int                pixels_taken  = 0;
  int                mismatches    = 0;
  bit                tx_pace = 1'b0;
  bit                rx_pace = 1'b0;

  // Zero reads as one; anything above the limit saturates
  function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_position();
    cur_col = 0;
    cur_row = 0;
    blk_col = 0;
    blk_row = 0;
    out_col = 0;
    acc_r   = '0;
    acc_g   = '0;
    acc_b   = '0;
  endfunction

  // Advance the predictor by one pixel; queue an average when a block closes
  task automatic predict_pixel(input logic [23:0] word);
    int unsigned      f, w, h, used_w, used_h, area;
    logic [SUM_W-1:0] tot_r, tot_g, tot_b;
    px_out_t          res;
    f      = clamp_reg(scale_reg, MAX_FACTOR);
    w      = clamp_reg(width_reg, MAX_WIDTH);
    h      = clamp_reg(height_reg, MAX_HEIGHT);
    used_w = (w / f) * f;
    used_h = (h / f) * f;

    // Pixels in the ragged right and bottom margins are dropped
    if (cur_row < used_h && cur_col < used_w) begin
      acc_r += word[7:0];
      acc_g += word[15:8];
      acc_b += word[23:16];
      blk_col++;
      if (blk_col >= f) begin
        tot_r = SUM_W'(acc_r);
        tot_g = SUM_W'(acc_g);
        tot_b = SUM_W'(acc_b);
        if (blk_row != 0) begin
          tot_r += col_store[out_col].red;
          tot_g += col_store[out_col].green;
          tot_b += col_store[out_col].blue;
        end
        if (blk_row + 1 >= f) begin
          area      = f * f;
          res.red   = CH_W'(tot_r / area);
          res.green = CH_W'(tot_g / area);
          res.blue  = CH_W'(tot_b / area);
          res.last  = (cur_row + 1 == used_h) && (out_col + 1 == w / f);
          expected_px.push_back(res);
        end else begin
          col_store[out_col] = '{blue: tot_b, green: tot_g, red: tot_r};
        end
        acc_r   = '0;
        acc_g   = '0;
        acc_b   = '0;
        blk_col = 0;
        out_col++;
      end
    end

    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      blk_col = 0;
      out_col = 0;
      acc_r   = '0;
      acc_g   = '0;
      acc_b   = '0;
      if (cur_row < used_h) begin
        blk_row++;
        if (blk_row >= f) blk_row = 0;
      end
      cur_row++;
      if (cur_row >= h) begin
        cur_row = 0;
        blk_row = 0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver: pop pending pixels, hold each until its transfer, then wait
  // out the gap drawn for it before offering the next
  // --------------------------------------------------------------------------
  int tx_hold = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_hold = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_pixel(s_tdata);
        pixels_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_hold > 0) begin
          tx_hold--;
          s_tvalid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          s_tdata  <= pixel_q.pop_front();
          s_tvalid <= 1'b1;
          tx_hold = tx_pace ? $urandom_range(0, MAX_GAP) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: check each transfer against the oldest prediction, then
  // drop tready for a randomly drawn stall
  // --------------------------------------------------------------------------
  int rx_hold = 0;

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : rx_side
    px_out_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{red: m_tdata[7:0], green: m_tdata[15:8], blue: m_tdata[23:16], last: m_tlast};
        if (expected_px.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output, expected none, actual %0h last %0b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = expected_px.pop_front();
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("frame_last", 8'(want.last), 8'(got.last));
        end
        rx_hold = rx_pace ? $urandom_range(0, MAX_GAP) : 0;
        m_tready <= (rx_hold == 0);
      end else if (!m_tready) begin
        if (rx_hold <= 1) begin
          m_tready <= 1'b1;
          rx_hold = 0;
        end else begin
          rx_hold--;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: give up after a long stretch with no transfer on any port
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequencing
  // --------------------------------------------------------------------------
  task automatic queue_pixel(input logic [23:0] word);
    pixel_q.push_back(word);
    pixels_queued++;
  endtask

  // Drive one register write; the predictor takes it at the same edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    bit hit;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    hit = 1'b1;
    case (idx)
      CFG_SCALE:  scale_reg  = val[FCT_W-1:0];
      CFG_WIDTH:  width_reg  = val;
      CFG_HEIGHT: height_reg = val;
      default:    hit = 1'b0;
    endcase
    if (hit) clear_position();
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued pixel has gone in and every average has come out,
  // then let the pipeline drain of blocks that produce nothing
  task automatic settle();
    wait (pixels_taken == pixels_queued);
    while (expected_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          random_px;
    int unsigned pick, f_val, w_val, h_val, fe, n, mask;

    scale_reg  = 1;
    width_reg  = MAX_WIDTH;
    height_reg = MAX_HEIGHT;
    clear_position();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: factor one passes every pixel straight through
    queue_pixel(24'h000000);
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'h55AA55);
    queue_pixel(24'hAA55AA);
    queue_pixel(24'($urandom));
    settle();

    // One 2x2 block at full scale; the sum 1019 must truncate to 254
    write_reg(CFG_SCALE, 2);
    write_reg(CFG_WIDTH, 2);
    write_reg(CFG_HEIGHT, 2);
    end_writes();
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'hFEFEFE);
    settle();

    // Factor wider than the frame: no block fits, nothing comes out
    write_reg(CFG_SCALE, 3);
    end_writes();
    repeat (4) queue_pixel(24'($urandom));
    settle();

    // Restart mid-frame, then check that the unused slot leaves position alone
    write_reg(CFG_SCALE, 2);
    write_reg(CFG_WIDTH, 4);
    end_writes();
    repeat (3) queue_pixel(24'($urandom));
    settle();
    write_reg(CFG_WIDTH, 4);
    end_writes();
    repeat (3) queue_pixel(24'($urandom));
    settle();
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    end_writes();
    repeat (5) queue_pixel(24'($urandom));
    settle();

    // Random phases: small frames, mostly whole frames, now and then cut short
    random_px = 0;
    while (random_px < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 19);
      if (pick < 12)      f_val = $urandom_range(1, 4);
      else if (pick < 17) f_val = $urandom_range(5, 16);
      else if (pick < 19) f_val = $urandom_range(17, 31);
      else                f_val = 0;
      fe    = clamp_reg(f_val, MAX_FACTOR);
      w_val = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 2 * fe + 3);
      h_val = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 2 * fe + 3);
      tx_pace = ($urandom_range(0, 2) != 0);
      rx_pace = ($urandom_range(0, 2) != 0);

      mask = $urandom_range(1, 15);
      if (mask[0]) write_reg(CFG_SCALE, CFG_DATA_W'(f_val));
      if (mask[1]) write_reg(CFG_WIDTH, CFG_DATA_W'(w_val));
      if (mask[2]) write_reg(CFG_HEIGHT, CFG_DATA_W'(h_val));
      if (mask[3]) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      end_writes();

      n = $urandom_range(1, 2) * clamp_reg(width_reg, MAX_WIDTH)
          * clamp_reg(height_reg, MAX_HEIGHT);
      if (n > 600) n = 600;
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
      repeat (n) queue_pixel(24'($urandom));
      random_px += n;
      settle();
    end

    // Zero factor and height, oversized width: the start of a saturated row
    tx_pace = ($urandom_range(0, 1) != 0);
    rx_pace = ($urandom_range(0, 1) != 0);
    write_reg(CFG_SCALE, 0);
    write_reg(CFG_WIDTH, 13'h1FFF);
    write_reg(CFG_HEIGHT, 0);
    end_writes();
    repeat (WIDE_PIXELS) queue_pixel(24'($urandom));
    settle();

    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ rgb_box_average_downscaler_unit.f @@
+incdir+rtl/core
rtl/core/rbad_pkg.sv
rtl/core/rbad_front.sv
rtl/core/rbad_queue.sv
rtl/core/rbad_back.sv
rtl/core/rgb_box_average_downscaler_unit.sv
dv/tb.sv
